// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; compiled first.
package spq_pkg;

    // Default number of queue slots
    localparam int DEPTH_DEFAULT = 8;

    // Field widths fixed by the item format
    localparam int TAG_W  = 16;
    localparam int VAL_W  = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 4;

    // Request command codes
    typedef logic [0:0] op_t;
    localparam op_t OP_INSERT = 1'b0;
    localparam op_t OP_REMOVE = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    remove;
        status_t status;
    } spq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// ===== sv/spq_if.sv =====
// Valid/ready channel interfaces for request and result beats.
// Depends on spq_pkg.
interface spq_req_if;
    logic                  valid;
    logic                  ready;
    spq_pkg::op_t          command;
    logic [15:0]           entry_tag;
    logic signed [31:0]    entry_value;
    logic [7:0]            entry_priority;

    modport source (output valid, command, entry_tag, entry_value, entry_priority,
                    input ready);
    modport sink   (input valid, command, entry_tag, entry_value, entry_priority,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                  valid;
    logic                  ready;
    spq_pkg::status_t      status;
    logic [15:0]           out_tag;
    logic signed [31:0]    out_value;
    logic [7:0]            out_priority;
    logic [3:0]            occupancy;

    modport source (output valid, status, out_tag, out_value, out_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, out_tag, out_value, out_priority, occupancy,
                    output ready);
endinterface

// ===== sv/spq_ctrl.sv =====
// Handshake controller: accepts request beats, holds result valid, issues commands.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  spq_pkg::op_t       in_command,
    output logic               out_valid,
    input  logic               out_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a new beat whenever the result register is free or being drained
    assign in_ready = (state_reg == ST_IDLE) || out_ready;
    assign accept   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_HOLD);

    // Decode the command against the current fill state
    always_comb
    begin
        cmd.load   = accept;
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        cmd.status = STATUS_OK;
        if (in_command == OP_INSERT)
        begin
            if (stat.full)
                cmd.status = STATUS_FULL;
            else
                cmd.insert = accept;
        end
        else
        begin
            if (stat.empty)
                cmd.status = STATUS_EMPTY;
            else
                cmd.remove = accept;
        end
    end

    // Advance the result-holding state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready && !accept)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/spq_dpath.sv =====
// Shift-register slot array with parallel priority compare and result register.
// Depends on spq_pkg.
module spq_dpath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_pkg::spq_cmd_t    cmd,
    input  logic [15:0]          entry_tag,
    input  logic signed [31:0]   entry_value,
    input  logic [7:0]           entry_priority,
    output spq_pkg::spq_stat_t   stat,
    output spq_pkg::status_t     status,
    output logic [15:0]          out_tag,
    output logic signed [31:0]   out_value,
    output logic [7:0]           out_priority,
    output logic [3:0]           occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [TAG_W-1:0]  slot_tag_reg   [DEPTH];
    logic [VAL_W-1:0]  slot_value_reg [DEPTH];
    logic [PRIO_W-1:0] slot_prio_reg  [DEPTH];
    logic [TAG_W-1:0]  slot_tag_next   [DEPTH];
    logic [VAL_W-1:0]  slot_value_next [DEPTH];
    logic [PRIO_W-1:0] slot_prio_next  [DEPTH];
    logic [DEPTH-1:0]  stay;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW+OCC_W-1:0] occ_wide;

    status_t           status_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [PRIO_W-1:0] out_prio_reg;
    logic [OCC_W-1:0]  occ_reg;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // Flag held slots that keep their place on insert (equal or higher priority)
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
            stay[k] = (CW'(k) < count_reg) && (slot_prio_reg[k] >= entry_priority);
    end

    // Per-slot next value: hold, take the new entry, or shift one place
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_slot
        always_comb
        begin
            slot_tag_next[k]   = slot_tag_reg[k];
            slot_value_next[k] = slot_value_reg[k];
            slot_prio_next[k]  = slot_prio_reg[k];
            if (cmd.insert && !stay[k])
            begin
                if (k == 0)
                begin
                    slot_tag_next[k]   = entry_tag;
                    slot_value_next[k] = entry_value;
                    slot_prio_next[k]  = entry_priority;
                end
                else if (stay[(k == 0) ? 0 : k-1])
                begin
                    slot_tag_next[k]   = entry_tag;
                    slot_value_next[k] = entry_value;
                    slot_prio_next[k]  = entry_priority;
                end
                else
                begin
                    slot_tag_next[k]   = slot_tag_reg[(k == 0) ? 0 : k-1];
                    slot_value_next[k] = slot_value_reg[(k == 0) ? 0 : k-1];
                    slot_prio_next[k]  = slot_prio_reg[(k == 0) ? 0 : k-1];
                end
            end
            else if (cmd.remove && (k < DEPTH - 1))
            begin
                slot_tag_next[k]   = slot_tag_reg[(k < DEPTH - 1) ? k+1 : k];
                slot_value_next[k] = slot_value_reg[(k < DEPTH - 1) ? k+1 : k];
                slot_prio_next[k]  = slot_prio_reg[(k < DEPTH - 1) ? k+1 : k];
            end
        end
    end

    // Hold slot payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            slot_tag_reg[k]   <= slot_tag_next[k];
            slot_value_reg[k] <= slot_value_next[k];
            slot_prio_reg[k]  <= slot_prio_next[k];
        end
    end

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + CW'(1);
        else if (cmd.remove)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    // Load the result register on every accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            occ_reg    <= occ_wide[OCC_W-1:0];
            if (cmd.remove)
            begin
                out_tag_reg   <= slot_tag_reg[0];
                out_value_reg <= slot_value_reg[0];
                out_prio_reg  <= slot_prio_reg[0];
            end
            else
            begin
                out_tag_reg   <= '0;
                out_value_reg <= '0;
                out_prio_reg  <= '0;
            end
        end
    end

    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = occ_reg;

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue top level: controller plus slot datapath.
// Depends on spq_pkg, spq_if, spq_ctrl, spq_dpath.
//
//   Channel  Dir  Beat contents
//   req      in   command, entry_tag, entry_value, entry_priority
//   rsp      out  status, out_tag, out_value, out_priority, occupancy
//
// One request beat per cycle while rsp is not stalled; each gives one result beat on the next cycle.
// The slot array compares all priorities in parallel and shifts the slots together.
// A new request is taken while the last result waits if rsp is drained that cycle.
// Reset empties the queue at once; no clearing pass.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_command (req.command),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    spq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .entry_tag      (req.entry_tag),
        .entry_value    (req.entry_value),
        .entry_priority (req.entry_priority),
        .stat           (stat),
        .status         (rsp.status),
        .out_tag        (rsp.out_tag),
        .out_value      (rsp.out_value),
        .out_priority   (rsp.out_priority),
        .occupancy      (rsp.occupancy)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted priority queue top level.
// Uses spq_pkg and the spq_req_if / spq_rsp_if channel interfaces.
// A local queue model predicts every result beat, which is checked in order.
`timescale 1ns / 100ps

module testbench;

    import spq_pkg::*;

    localparam int  DEPTH       = DEPTH_DEFAULT;
    localparam int  CLK_PERIOD  = 10;
    localparam int  DRAIN_LIMIT = 5000;

    typedef struct {
        logic [TAG_W-1:0]         tag;
        logic signed [VAL_W-1:0]  value;
        logic [PRIO_W-1:0]        prio;
    } slot_t;

    typedef struct {
        status_t                  status;
        logic [TAG_W-1:0]         tag;
        logic signed [VAL_W-1:0]  value;
        logic [PRIO_W-1:0]        prio;
        logic [OCC_W-1:0]         occupancy;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req ();
    spq_rsp_if rsp ();

    sorted_priority_queue_top #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Model state: sorted slots, highest priority in slot 0
    slot_t       model_slots [DEPTH];
    int unsigned model_held;

    result_t     expected_results [$];

    int error_count    = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int full_drops     = 0;
    int empty_removes  = 0;
    bit send_gaps_on   = 1'b0;
    bit rsp_stalls_on  = 1'b0;
    int ready_hold     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Apply one request to the model and return the result it gives
    function automatic result_t queue_step(op_t cmd, logic [TAG_W-1:0] tag,
                                           logic signed [VAL_W-1:0] value,
                                           logic [PRIO_W-1:0] prio);
        result_t     res;
        int unsigned pos;
        res.status = STATUS_OK;
        res.tag    = '0;
        res.value  = '0;
        res.prio   = '0;
        if (cmd == OP_INSERT) begin
            if (model_held >= DEPTH) begin
                res.status = STATUS_FULL;
            end
            else begin
                // Go behind every entry of equal or higher priority
                pos = 0;
                while (pos < model_held && model_slots[pos].prio >= prio)
                    pos++;
                for (int k = model_held; k > pos; k--)
                    model_slots[k] = model_slots[k-1];
                model_slots[pos].tag   = tag;
                model_slots[pos].value = value;
                model_slots[pos].prio  = prio;
                model_held++;
            end
        end
        else begin
            if (model_held == 0) begin
                res.status = STATUS_EMPTY;
            end
            else begin
                res.tag   = model_slots[0].tag;
                res.value = model_slots[0].value;
                res.prio  = model_slots[0].prio;
                for (int k = 0; k + 1 < model_held; k++)
                    model_slots[k] = model_slots[k+1];
                model_held--;
            end
        end
        res.occupancy = model_held[OCC_W-1:0];
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Send one request beat; leave valid high when the next beat follows at once
    task automatic send_beat(op_t cmd, logic [TAG_W-1:0] tag,
                             logic signed [VAL_W-1:0] value, logic [PRIO_W-1:0] prio);
        result_t res;
        int      gap;
        req.valid          <= 1'b1;
        req.command        <= cmd;
        req.entry_tag      <= tag;
        req.entry_value    <= value;
        req.entry_priority <= prio;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // Beat taken at this edge: predict its result
        res = queue_step(cmd, tag, value, prio);
        if (res.status == STATUS_FULL)
            full_drops++;
        if (res.status == STATUS_EMPTY)
            empty_removes++;
        expected_results.push_back(res);
        beats_sent++;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_all_results();
        int n;
        n = 0;
        req.valid <= 1'b0;
        while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic send_random(int insert_pct, bit narrow_prio);
        op_t              cmd;
        logic [PRIO_W-1:0] prio;
        int               pick;
        cmd = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if (narrow_prio) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: prio = 8'd0;
                1: prio = 8'd1;
                2: prio = 8'd2;
                3: prio = 8'd254;
                default: prio = 8'd255;
            endcase
        end
        else begin
            prio = PRIO_W'($urandom_range(0, 255));
        end
        send_beat(cmd, TAG_W'($urandom_range(0, 65535)), VAL_W'($urandom), prio);
    endtask

    // Removes on an empty queue, with extreme field values that must be ignored
    task automatic test_remove_when_empty();
        send_beat(OP_REMOVE, 16'hFFFF, 32'sh80000000, 8'hFF);
        send_beat(OP_REMOVE, 16'h0000, 32'sh7FFFFFFF, 8'h00);
        wait_all_results();
    endtask

    // Fill with field extremes and tied priorities, overflow, then drain past empty
    task automatic test_fill_overflow_drain();
        send_beat(OP_INSERT, 16'h0000, 32'sh7FFFFFFF, 8'd255);
        send_beat(OP_INSERT, 16'hFFFF, 32'sh80000000, 8'd0);
        send_beat(OP_INSERT, 16'h0001, -32'sd1,       8'd7);
        send_beat(OP_INSERT, 16'h0002, 32'sd0,        8'd7);
        send_beat(OP_INSERT, 16'h0003, 32'sd1,        8'd255);
        send_beat(OP_INSERT, 16'h0004, 32'sh55555555, 8'd7);
        send_beat(OP_INSERT, 16'h0005, 32'shAAAAAAAA, 8'd0);
        send_beat(OP_INSERT, 16'h0006, 32'sd12345,    8'd128);
        send_beat(OP_INSERT, 16'hFFFF, 32'sh7FFFFFFF, 8'd255);
        send_beat(OP_INSERT, 16'h1234, 32'sh80000000, 8'd0);
        repeat (DEPTH + 1)
            send_beat(OP_REMOVE, 16'h0000, 32'sd0, 8'd0);
        wait_all_results();
    endtask

    // Full-rate traffic with no idling on either side
    task automatic test_back_to_back();
        send_gaps_on  = 1'b0;
        rsp_stalls_on = 1'b0;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 2)
                send_beat(OP_REMOVE, TAG_W'($urandom_range(0, 65535)), VAL_W'($urandom),
                          PRIO_W'($urandom_range(0, 255)));
            else
                send_beat(OP_INSERT, TAG_W'($urandom_range(0, 65535)), VAL_W'($urandom),
                          PRIO_W'($urandom_range(0, 255)));
        end
        wait_all_results();
    endtask

    // Chunks that push the queue toward full, toward empty, or hold it in between
    task automatic test_random_mix();
        for (int chunk = 0; chunk < 35; chunk++) begin
            send_gaps_on  = (chunk % 4 == 1) || (chunk % 4 == 3);
            rsp_stalls_on = (chunk % 4 == 2) || (chunk % 4 == 3);
            for (int i = 0; i < 50; i++) begin
                case (chunk % 5)
                    0: send_random(80, 1'b0);
                    1: send_random(20, 1'b0);
                    2: send_random(50, 1'b0);
                    3: send_random(55, 1'b1);
                    default: send_random(60, 1'($urandom_range(0, 1)));
                endcase
            end
            if (chunk % 7 == 6)
                wait_all_results();
        end
        req.valid <= 1'b0;
    endtask

    // Drive the result ready with random stalls
    always @(posedge clk) begin
        if (!rsp_stalls_on) begin
            rsp.ready  <= 1'b1;
            ready_hold <= 0;
        end
        else if (ready_hold > 0) begin
            rsp.ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if ($urandom_range(0, 99) < 30) begin
            rsp.ready  <= 1'b0;
            ready_hold <= pick_gap();
        end
        else begin
            rsp.ready <= 1'b1;
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge clk) begin
        result_t exp;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no request pending");
            end
            else begin
                exp = expected_results.pop_front();
                if (rsp.status !== exp.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              rsp.status, exp.status));
                if (rsp.out_tag !== exp.tag)
                    report_mismatch($sformatf("out_tag got %h exp %h",
                                              rsp.out_tag, exp.tag));
                if (rsp.out_value !== exp.value)
                    report_mismatch($sformatf("out_value got %0d exp %0d",
                                              rsp.out_value, exp.value));
                if (rsp.out_priority !== exp.prio)
                    report_mismatch($sformatf("out_priority got %0d exp %0d",
                                              rsp.out_priority, exp.prio));
                if (rsp.occupancy !== exp.occupancy)
                    report_mismatch($sformatf("occupancy got %0d exp %0d",
                                              rsp.occupancy, exp.occupancy));
            end
        end
    end

    // Bound the run
    initial begin
        #10_000_000;
        $display("timeout with %0d results pending", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        // Start every input at a known value and reset
        rst_n              <= 1'b0;
        req.valid          <= 1'b0;
        req.command        <= OP_INSERT;
        req.entry_tag      <= '0;
        req.entry_value    <= '0;
        req.entry_priority <= '0;
        model_held = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_remove_when_empty();
        test_fill_overflow_drain();
        test_back_to_back();
        test_random_mix();

        // Drain, then report any predicted result that never arrived
        wait_all_results();
        while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("covered %0d request beats and %0d result beats, with ties and field extremes",
                 beats_sent, results_seen);
        $display("inserts dropped when full: %0d, removes on empty: %0d",
                 full_drops, empty_removes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_ctrl.sv
sv/spq_dpath.sv
sv/sorted_priority_queue_top.sv
tb/testbench.sv
